// ===== rtl/core/esw_pkg.sv =====
// Shared types and constants for the elevator sweep ordering block.
// No dependencies; imported by every module under rtl/core.
package esw_pkg;

    localparam int FLOOR_W = 8;

    typedef logic [FLOOR_W-1:0] floor_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_LO_RD,
        ST_GAP_LO,
        ST_GAP_HI,
        ST_DIR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } seq_state_t;

    // Result of the shared compare/subtract unit
    typedef struct packed {
        logic   gt;   // a > b
        floor_t mag;  // |a - b|
    } alu_res_t;

endpackage

// ===== rtl/core/esw_alu.sv =====
// Shared compare/subtract unit: one 9-bit subtract gives a > b and |a - b|.
// Depends on esw_pkg.
module esw_alu
    import esw_pkg::*;
(
    input  floor_t   a,
    input  floor_t   b,
    output alu_res_t res
);

    logic [FLOOR_W:0] diff;
    logic             borrow;

    assign diff   = {1'b0, a} - {1'b0, b};
    assign borrow = diff[FLOOR_W];

    always_comb
    begin
        res.gt  = !borrow && (diff[FLOOR_W-1:0] != '0);
        res.mag = borrow ? floor_t'(~diff[FLOOR_W-1:0] + 1'b1) : diff[FLOOR_W-1:0];
    end

endmodule

// ===== rtl/core/esw_store.sv =====
// Request store: one write port, one read port with registered read data.
// Depends on esw_pkg.
module esw_store
    import esw_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  floor_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output floor_t        rd_data
);

    floor_t mem [DEPTH];
    floor_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/esw_seq.sv =====
// Sequencer: insertion on arrival, direction choice, and arrival emission.
// Depends on esw_pkg; drives esw_store and esw_alu from the top level.
module esw_seq
    import esw_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int CW    = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    // request side
    input  logic          in_valid,
    output logic          in_ready,
    input  floor_t        in_floor,
    input  logic          in_end,
    // store
    output logic [AW-1:0] rd_addr,
    input  floor_t        rd_data,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output floor_t        wr_data,
    // shared unit
    output floor_t        alu_a,
    output floor_t        alu_b,
    input  alu_res_t      alu_res,
    // output register
    input  logic          out_busy,
    output logic          out_load,
    output floor_t        out_floor,
    output logic          out_up,
    output logic          out_last
);

    seq_state_t    state_reg, state_next;
    floor_t        key_reg;
    logic          end_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] idx_reg;
    floor_t        gap_lo_reg;
    floor_t        gap_hi_reg;
    logic          up_reg;
    floor_t        car_reg;

    logic          accept;
    logic          has_room;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] last_idx;
    logic          at_last;

    assign accept   = in_valid && in_ready;
    assign has_room = count_reg < CW'(DEPTH);
    assign cnt_m1   = count_reg - CW'(1);
    assign last_idx = cnt_m1[AW-1:0];
    assign at_last  = idx_reg == last_idx;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (has_room)
                        state_next = ST_INS_RD;
                    else if (in_end)
                        state_next = ST_LO_RD;
                end
            end
            ST_INS_RD:
            begin
                if (idx_reg == '0)
                    state_next = end_reg ? ST_LO_RD : ST_IDLE;
                else
                    state_next = ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                if (alu_res.gt)
                    state_next = ST_INS_RD;
                else
                    state_next = end_reg ? ST_LO_RD : ST_IDLE;
            end
            ST_LO_RD:   state_next = ST_GAP_LO;
            ST_GAP_LO:  state_next = ST_GAP_HI;
            ST_GAP_HI:  state_next = ST_DIR;
            ST_DIR:     state_next = ST_EMIT_RD;
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD:
            begin
                if (!out_busy)
                    state_next = at_last ? ST_IDLE : ST_EMIT_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = key_reg;
        alu_a     = rd_data;
        alu_b     = key_reg;
        out_load  = 1'b0;
        out_floor = rd_data;
        out_up    = up_reg;
        out_last  = at_last;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_INS_RD:
            begin
                rd_addr = idx_reg - AW'(1);
                wr_en   = (idx_reg == '0);
            end
            ST_INS_CMP:
            begin
                wr_en   = 1'b1;
                wr_data = alu_res.gt ? rd_data : key_reg;
            end
            ST_LO_RD:
            begin
                rd_addr = '0;
            end
            ST_GAP_LO:
            begin
                rd_addr = last_idx;
                alu_b   = car_reg;
            end
            ST_GAP_HI:
            begin
                alu_b = car_reg;
            end
            ST_DIR:
            begin
                alu_a = gap_lo_reg;
                alu_b = gap_hi_reg;
            end
            ST_EMIT_RD, ST_EMIT_LD:
            begin
                rd_addr  = up_reg ? idx_reg : last_idx - idx_reg;
                out_load = (state_reg == ST_EMIT_LD) && !out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            car_reg   <= floor_t'(1);
            idx_reg   <= '0;
            end_reg   <= 1'b0;
            up_reg    <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        end_reg <= in_end;
                        if (has_room)
                        begin
                            idx_reg   <= count_reg[AW-1:0];
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                end
                ST_INS_CMP:
                begin
                    if (alu_res.gt)
                        idx_reg <= idx_reg - AW'(1);
                end
                ST_DIR:
                begin
                    up_reg  <= !alu_res.gt;
                    idx_reg <= '0;
                end
                ST_EMIT_LD:
                begin
                    if (!out_busy)
                    begin
                        car_reg <= rd_data;
                        if (at_last)
                            count_reg <= '0;
                        else
                            idx_reg <= idx_reg + AW'(1);
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (accept)
            key_reg <= in_floor;
        if (state_reg == ST_GAP_LO)
            gap_lo_reg <= alu_res.mag;
        if (state_reg == ST_GAP_HI)
            gap_hi_reg <= alu_res.mag;
    end

endmodule

// ===== rtl/core/elevator_sweep_order.sv =====
// Top level of the elevator sweep ordering block (SCAN order of a rider group).
// Depends on esw_pkg, esw_alu, esw_store and esw_seq.
//
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata = dest_floor, tlast = group_end
// m_axis    out  m_axis_tvalid/tready    tdata = arrive_floor, tuser = going_up,
//                                        tlast = final_stop
//
// Insertion: ST_INS_RD reads the entry below the request's slot and ST_INS_CMP
// compares it on the shared compare/subtract unit, shifting it up one slot through
// the one store port; slot 0 is written in ST_INS_RD. Dropped requests are just taken.
// A group end steps through ST_LO_RD, ST_GAP_LO, ST_GAP_HI and ST_DIR to pick the
// sweep direction; per arrival word ST_EMIT_RD reads the store and ST_EMIT_LD loads it.
// Reset: request count 0, car floor 1; the store itself is not cleared.
// A stalled m_axis holds the sequencer in its emit step; s_axis is not ready
// until the group's last arrival word sits in the output register.
module elevator_sweep_order
    import esw_pkg::*;
#(
    parameter int MAX_RIDERS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] dest_floor
    input  logic       s_axis_tlast,   // group_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] arrive_floor
    output logic       m_axis_tuser,   // [0] going_up
    output logic       m_axis_tlast    // final_stop
);

    localparam int AW = (MAX_RIDERS > 1) ? $clog2(MAX_RIDERS) : 1;
    localparam int CW = $clog2(MAX_RIDERS + 1);

    logic [AW-1:0] rd_addr;
    floor_t        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    floor_t        wr_data;
    floor_t        alu_a;
    floor_t        alu_b;
    alu_res_t      alu_res;

    logic          out_busy;
    logic          out_load;
    floor_t        out_floor;
    logic          out_up;
    logic          out_last;

    // output word register
    logic          out_valid_reg, out_valid_next;
    floor_t        out_floor_reg;
    logic          out_up_reg;
    logic          out_last_reg;

    assign out_busy = out_valid_reg && !m_axis_tready;

    esw_store #(
        .DEPTH (MAX_RIDERS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    esw_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    esw_seq #(
        .DEPTH (MAX_RIDERS),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_floor  (s_axis_tdata),
        .in_end    (s_axis_tlast),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .alu_a     (alu_a),
        .alu_b     (alu_b),
        .alu_res   (alu_res),
        .out_busy  (out_busy),
        .out_load  (out_load),
        .out_floor (out_floor),
        .out_up    (out_up),
        .out_last  (out_last)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_floor_reg <= out_floor;
            out_up_reg    <= out_up;
            out_last_reg  <= out_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_floor_reg;
    assign m_axis_tuser  = out_up_reg;
    assign m_axis_tlast  = out_last_reg;

    // a new arrival word never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("arrival word overwritten");

    // the last arrival of a group frees the request side next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last) |=> s_axis_tready)
        else $error("request side not freed after final arrival");

    // a group end always starts work, so the request side closes
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("group end did not start a sweep");

endmodule

// ===== sim/esw_sweep_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for elevator_sweep_order: watches both streams, predicts the arrival words
// of every closed group and compares them field by field. Depends on esw_pkg only.
module esw_sweep_checker
    import esw_pkg::*;
#(
    parameter int MAX_RIDERS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_ready,
    input  logic [7:0] req_floor,
    input  logic       req_last,
    input  logic       arr_valid,
    input  logic       arr_ready,
    input  logic [7:0] arr_floor,
    input  logic       arr_up,
    input  logic       arr_last,
    output int         mismatches,
    output int         pending,
    output int         arrivals_seen,
    output floor_t     car_now
);

    typedef struct packed {
        floor_t floor;
        logic   up;
        logic   last;
    } arrival_t;

    arrival_t due_arrivals[$];
    floor_t   boarded[MAX_RIDERS];   // kept sorted ascending
    int       boarded_n;

    function automatic int floor_dist(input floor_t a, input floor_t b);
        return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 20)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Store one request (dropped when full); on group close queue the sweep.
    task automatic board_rider(input floor_t f, input logic closes);
        int       i;
        logic     up;
        arrival_t a;
        if (boarded_n < MAX_RIDERS)
        begin
            i = boarded_n;
            while (i > 0 && boarded[i-1] > f)
            begin
                boarded[i] = boarded[i-1];
                i--;
            end
            boarded[i] = f;
            boarded_n++;
        end
        if (closes && boarded_n > 0)
        begin
            // tie goes to the upward sweep
            up = floor_dist(boarded[0], car_now) <= floor_dist(boarded[boarded_n-1], car_now);
            for (i = 0; i < boarded_n; i++)
            begin
                a.floor = up ? boarded[i] : boarded[boarded_n-1-i];
                a.up    = up;
                a.last  = (i == boarded_n - 1);
                due_arrivals.push_back(a);
            end
            car_now = a.floor;
        end
        if (closes)
            boarded_n = 0;
    endtask

    task automatic check_arrival();
        arrival_t a;
        if (due_arrivals.size() == 0)
        begin
            report_mismatch($sformatf("arrival word floor %0d with nothing due", arr_floor));
        end
        else
        begin
            a = due_arrivals.pop_front();
            if (arr_floor !== a.floor)
                report_mismatch($sformatf("arrive_floor %0d, due %0d", arr_floor, a.floor));
            if (arr_up !== a.up)
                report_mismatch($sformatf("going_up %b, due %b (floor %0d)",
                                          arr_up, a.up, a.floor));
            if (arr_last !== a.last)
                report_mismatch($sformatf("final_stop %b, due %b (floor %0d)",
                                          arr_last, a.last, a.floor));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_arrivals.delete();
            boarded_n = 0;
            car_now   = 8'd1;
            pending   = 0;
        end
        else
        begin
            // drain before fill: a word leaving now is never one queued at this edge
            if (arr_valid && arr_ready)
            begin
                check_arrival();
                arrivals_seen++;
            end
            if (req_valid && req_ready)
                board_rider(req_floor, req_last);
            pending = due_arrivals.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for elevator_sweep_order: drives request groups with random idling and
// back-pressure, and gives the verdict. Depends on esw_pkg and esw_sweep_checker.
module tb_top
    import esw_pkg::*;
();

    localparam int MAX_RIDERS  = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;     // long receiver stall, enough to back up s_axis

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;   // [7:0] dest_floor
    logic       s_axis_tlast = 1'b0;   // group_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] arrive_floor
    logic       m_axis_tuser;          // [0] going_up
    logic       m_axis_tlast;          // final_stop

    int     mismatches;
    int     pending;
    int     arrivals_seen;
    floor_t car_now;

    int     src_idle_pct  = 31;
    int     sink_idle_pct = 51;
    logic   sink_hold = 1'b0;
    int     requests_sent = 0;
    int     groups_sent = 0;
    int     cycle_count = 0;
    event   long_hold_ev;

    always #5 clk = ~clk;

    elevator_sweep_order #(
        .MAX_RIDERS(MAX_RIDERS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    esw_sweep_checker #(
        .MAX_RIDERS(MAX_RIDERS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (s_axis_tvalid),
        .req_ready    (s_axis_tready),
        .req_floor    (s_axis_tdata),
        .req_last     (s_axis_tlast),
        .arr_valid    (m_axis_tvalid),
        .arr_ready    (m_axis_tready),
        .arr_floor    (m_axis_tdata),
        .arr_up       (m_axis_tuser),
        .arr_last     (m_axis_tlast),
        .mismatches   (mismatches),
        .pending      (pending),
        .arrivals_seen(arrivals_seen),
        .car_now      (car_now)
    );

    // Receiver: random tready, forced low while a long hold is running.
    always @(negedge clk)
        m_axis_tready <= sink_hold ? 1'b0 : ($urandom_range(99) >= sink_idle_pct);

    // Long hold: counted here so the sender keeps offering words meanwhile.
    initial
    begin
        forever
        begin
            @(long_hold_ev);
            sink_hold = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            sink_hold = 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d arrival words still due",
                     cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One request word. Called and returns at a falling edge; tvalid stays high
    // into the next word when no gap is drawn.
    task automatic send_request(input floor_t f, input logic closes);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        s_axis_tlast  <= closes;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        requests_sent++;
        if (closes)
            groups_sent++;
    endtask

    // Sender pause until the checker has nothing left due.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Random group. Most fit the store; about one in five overflows it so the
    // closing word is often a dropped one.
    task automatic send_random_group();
        int     n;
        int     shape;
        int     d;
        int     i;
        floor_t base;
        floor_t lo;
        floor_t hi;
        floor_t f;
        n = ($urandom_range(99) < 80) ? $urandom_range(1, MAX_RIDERS)
                                      : $urandom_range(MAX_RIDERS + 1, MAX_RIDERS + 4);
        shape = $urandom_range(3);
        base  = floor_t'($urandom_range(255));
        // bracket the car floor symmetrically so both ends are equally far
        d = $urandom_range(1, 40);
        if (d > car_now)
            d = int'(car_now);
        if (d > 255 - car_now)
            d = 255 - car_now;
        lo = floor_t'(int'(car_now) - d);
        hi = floor_t'(int'(car_now) + d);
        for (i = 0; i < n; i++)
        begin
            case (shape)
                0: f = floor_t'($urandom_range(255));
                1: f = base + floor_t'($urandom_range(15));         // tight cluster
                2: f = (i == 0) ? lo : (i == 1) ? hi : floor_t'($urandom_range(hi, lo));
                default:
                begin
                    f = 8'h01 << $urandom_range(7);                  // walking bits
                    if ($urandom_range(1))
                        f = ~f;
                end
            endcase
            send_request(f, i == n - 1);
        end
    endtask

    task automatic run_random_until(input int total);
        while (requests_sent < total)
            send_random_group();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Car starts at floor 1.
        send_request(8'd0, 1'b1);      // single rider, bottom floor, tie -> up
        send_request(8'd255, 1'b1);    // single rider, top floor
        // full store, closing on the 8th word; car at 255 -> down sweep
        send_request(8'd10, 1'b0);
        send_request(8'd200, 1'b0);
        send_request(8'd50, 1'b0);
        send_request(8'd50, 1'b0);
        send_request(8'd255, 1'b0);
        send_request(8'd0, 1'b0);
        send_request(8'd128, 1'b0);
        send_request(8'd1, 1'b1);
        // overflow: words 9 and 10 are dropped, the dropped 10th still closes the group
        send_request(8'd3, 1'b0);
        send_request(8'd250, 1'b0);
        send_request(8'd17, 1'b0);
        send_request(8'd99, 1'b0);
        send_request(8'd180, 1'b0);
        send_request(8'd42, 1'b0);
        send_request(8'd77, 1'b0);
        send_request(8'd128, 1'b0);
        send_request(8'd5, 1'b0);
        send_request(8'd200, 1'b1);
        // car at 250: both ends 5 floors away, tie -> up
        send_request(8'd245, 1'b0);
        send_request(8'd255, 1'b1);
        // car at 255: duplicates, high end nearer -> down
        send_request(8'd200, 1'b0);
        send_request(8'd254, 1'b0);
        send_request(8'd200, 1'b1);

        // Phase 1: sender idles 31%, receiver 51%
        run_random_until(150);
        wait_drained();

        // Phase 2: the other way round
        src_idle_pct  = 51;
        sink_idle_pct = 31;
        run_random_until(300);

        // Phase 3: no idling, but first a long receiver hold while requests keep coming
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        -> long_hold_ev;
        run_random_until(450);

        wait_drained();
        repeat (40) @(posedge clk);   // catch any stray arrival word

        $display("Sent %0d requests in %0d groups, checked %0d arrival words", requests_sent,
                 groups_sent, arrivals_seen);
        $display("Covered full and overflowing groups, tied sweeps and long back-pressure");
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
